/* design/scu_pkg.sv */
// ----------------------------------------------------------------------------
// scu_pkg
// Constants for the symmetrical component unbalance pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package scu_pkg;

	// default phasor part width
	localparam int SAMPLE_WIDTH_DEF = 24;

	// sqrt(3)/2 in Q16
	localparam int ROOT3_HALF_Q16 = 56756;

	// half of 3 * 2^16, rounding offset of the divide by three
	localparam int ROUND_Q16 = 98304;

	// ratio scale: hundredths of a percent
	localparam int RATIO_SCALE = 10000;

	// ratio output width, also the number of quotient steps
	localparam int RATIO_BITS = 16;

endpackage

`default_nettype wire

/* design/symmetrical_component_unbalance.sv */
// ----------------------------------------------------------------------------
// symmetrical_component_unbalance
// Fortescue zero, positive and negative sequence components of one
// three-phase phasor set, with negative and zero unbalance ratios.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_ready, one transaction carries the
//   rectangular phasors of phases a, b and c for one harmonic.
//   output channel: out_valid / out_ready, one transaction per input
//   transaction, carrying the three sequence phasors, both unbalance ratios
//   in hundredths of a percent (saturating at 65535) and no_positive.
//   throughput: one transaction per cycle, sustained while out_ready stays high.
//   pipeline: seven arithmetic stages, one stage per root bit of the three
//   pipelined square roots, one dividend stage and one stage per quotient
//   bit of the two pipelined restoring dividers.
//   each stage holds a valid bit; a stage loads whenever it is empty or the
//   stage after it moves, so a stalled receiver first lets the bubbles in
//   the pipe close up and in_ready only drops once every stage is full.
//   nothing is lost or repeated across a stall.
//   reset clears all valid bits; the datapath registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module symmetrical_component_unbalance #(
	parameter int SAMPLE_WIDTH = scu_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] phase_a_re,
	input  logic signed [SAMPLE_WIDTH-1:0] phase_a_im,
	input  logic signed [SAMPLE_WIDTH-1:0] phase_b_re,
	input  logic signed [SAMPLE_WIDTH-1:0] phase_b_im,
	input  logic signed [SAMPLE_WIDTH-1:0] phase_c_re,
	input  logic signed [SAMPLE_WIDTH-1:0] phase_c_im,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] zero_seq_re,
	output logic signed [SAMPLE_WIDTH-1:0] zero_seq_im,
	output logic signed [SAMPLE_WIDTH-1:0] pos_seq_re,
	output logic signed [SAMPLE_WIDTH-1:0] pos_seq_im,
	output logic signed [SAMPLE_WIDTH-1:0] neg_seq_re,
	output logic signed [SAMPLE_WIDTH-1:0] neg_seq_im,
	output logic [scu_pkg::RATIO_BITS-1:0] neg_unbalance,
	output logic [scu_pkg::RATIO_BITS-1:0] zero_unbalance,
	output logic                           no_positive
);

	localparam int W    = SAMPLE_WIDTH;
	localparam int RB   = scu_pkg::RATIO_BITS;
	// numerator width in 2^-16 input lsb
	localparam int NW   = W + 19;
	// divide by three by reciprocal: floor(t * KDIV3 / 2^NSH) for t < 2^(W+1)
	localparam int NSH  = W + 2;
	localparam logic [W:0] KDIV3 = (W+1)'(((64'd1 << NSH) / 3) + 1);
	// clamp of the rounded quotient input; anything above saturates anyway
	localparam logic [W:0] TMAX = (W+1)'((64'd3 << (W - 1)) + 2);
	// dividend width of the ratio divider
	localparam int DW   = W + 16;
	// stage numbers
	localparam int S_SQ = 8;
	localparam int S_DV = S_SQ + W;
	localparam int L    = S_DV + RB;

	// ------------------------------------------------------------------------
	// valid bits and stage ready chain
	// ------------------------------------------------------------------------
	logic [L:1] vld_q;
	logic [L:1] rdy;

	always_comb begin
		rdy[L] = !vld_q[L] || out_ready;
		for (int k = L - 1; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= L; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = rdy[1];
	assign out_valid = vld_q[L];

	// ------------------------------------------------------------------------
	// stage 1: phase sums and differences
	// sum = a + b + c, b2 = 2a - b - c, d_re = b_im - c_im, d_im = b_re - c_re
	// ------------------------------------------------------------------------
	logic signed [W+2:0] ar_x, ai_x, br_x, bi_x, cr_x, ci_x;
	logic signed [W+2:0] sum_re_c, sum_im_c, dre_c, dim_c;
	logic signed [W+1:0] sum_re_s1, sum_im_s1;
	logic signed [W+2:0] b2_re_s1, b2_im_s1;
	logic signed [W:0]   d_re_s1, d_im_s1;

	always_comb begin
		ar_x     = (W+3)'(phase_a_re);
		ai_x     = (W+3)'(phase_a_im);
		br_x     = (W+3)'(phase_b_re);
		bi_x     = (W+3)'(phase_b_im);
		cr_x     = (W+3)'(phase_c_re);
		ci_x     = (W+3)'(phase_c_im);
		sum_re_c = ar_x + br_x + cr_x;
		sum_im_c = ai_x + bi_x + ci_x;
		dre_c    = bi_x - ci_x;
		dim_c    = br_x - cr_x;
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			sum_re_s1 <= sum_re_c[W+1:0];
			sum_im_s1 <= sum_im_c[W+1:0];
			b2_re_s1  <= (ar_x <<< 1) - br_x - cr_x;
			b2_im_s1  <= (ai_x <<< 1) - bi_x - ci_x;
			d_re_s1   <= dre_c[W:0];
			d_im_s1   <= dim_c[W:0];
		end
	end

	// ------------------------------------------------------------------------
	// stage 2: rotation products by sqrt(3)/2
	// ------------------------------------------------------------------------
	logic signed [W+1:0]  sum_re_s2, sum_im_s2;
	logic signed [W+2:0]  b2_re_s2, b2_im_s2;
	logic signed [NW-1:0] rot_re_s2, rot_im_s2;

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			sum_re_s2 <= sum_re_s1;
			sum_im_s2 <= sum_im_s1;
			b2_re_s2  <= b2_re_s1;
			b2_im_s2  <= b2_im_s1;
			rot_re_s2 <= NW'(d_re_s1) * NW'(scu_pkg::ROOT3_HALF_Q16);
			rot_im_s2 <= NW'(d_im_s1) * NW'(scu_pkg::ROOT3_HALF_Q16);
		end
	end

	// ------------------------------------------------------------------------
	// stage 3: six q16 numerators, magnitude, round, drop 16 bits, clamp
	// order: zero re/im, pos re/im, neg re/im
	// ------------------------------------------------------------------------
	logic signed [NW-1:0] base_re_c, base_im_c;
	logic signed [NW-1:0] num_c [6];
	logic [NW-1:0]        mag_c [6];
	logic [NW-1:0]        rnd_c [6];
	logic [W:0]           t_c   [6];
	logic [W:0]           t_s3  [6];
	logic [5:0]           neg_s3;

	always_comb begin
		base_re_c = NW'(b2_re_s2) <<< 15;
		base_im_c = NW'(b2_im_s2) <<< 15;
		num_c[0]  = NW'(sum_re_s2) <<< 16;
		num_c[1]  = NW'(sum_im_s2) <<< 16;
		num_c[2]  = base_re_c - rot_re_s2;
		num_c[3]  = base_im_c + rot_im_s2;
		num_c[4]  = base_re_c + rot_re_s2;
		num_c[5]  = base_im_c - rot_im_s2;
		for (int i = 0; i < 6; i++) begin
			mag_c[i] = num_c[i][NW-1] ? NW'(-num_c[i]) : NW'(num_c[i]);
			rnd_c[i] = (mag_c[i] + NW'(scu_pkg::ROUND_Q16)) >> 16;
			t_c[i]   = (rnd_c[i] > NW'(TMAX)) ? TMAX : rnd_c[i][W:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			for (int i = 0; i < 6; i++) begin
				t_s3[i]   <= t_c[i];
				neg_s3[i] <= num_c[i][NW-1];
			end
		end
	end

	// ------------------------------------------------------------------------
	// stage 4: divide by three by reciprocal multiply
	// ------------------------------------------------------------------------
	logic [2*W+1:0] prod_c [6];
	logic [W-1:0]   q_s4   [6];
	logic [5:0]     neg_s4;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			prod_c[i] = (2*W+2)'(t_s3[i]) * (2*W+2)'(KDIV3);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			for (int i = 0; i < 6; i++) begin
				q_s4[i] <= prod_c[i][NSH +: W];
			end
			neg_s4 <= neg_s3;
		end
	end

	// ------------------------------------------------------------------------
	// stage 5: saturate to the sample range and restore the sign
	// ------------------------------------------------------------------------
	localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
	logic [5:0][W-1:0] comp_s5;

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			for (int i = 0; i < 6; i++) begin
				if (neg_s4[i]) begin
					comp_s5[i] <= W'(-q_s4[i]);
				end else begin
					comp_s5[i] <= (q_s4[i] > LIM_POS) ? LIM_POS : q_s4[i];
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// stage 6: squares of the part magnitudes
	// ------------------------------------------------------------------------
	logic [W-1:0]      abs_c [6];
	logic [2*W-1:0]    sq_s6 [6];
	logic [5:0][W-1:0] comp_s6;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			abs_c[i] = comp_s5[i][W-1] ? W'(-comp_s5[i]) : comp_s5[i];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			for (int i = 0; i < 6; i++) begin
				sq_s6[i] <= (2*W)'(abs_c[i]) * (2*W)'(abs_c[i]);
			end
			comp_s6 <= comp_s5;
		end
	end

	// ------------------------------------------------------------------------
	// stage 7: squared magnitudes, 0 zero, 1 pos, 2 neg
	// ------------------------------------------------------------------------
	logic [2*W-1:0]    msq_s7 [3];
	logic [5:0][W-1:0] comp_s7;

	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			for (int m = 0; m < 3; m++) begin
				msq_s7[m] <= sq_s6[2*m] + sq_s6[2*m+1];
			end
			comp_s7 <= comp_s6;
		end
	end

	// ------------------------------------------------------------------------
	// stages 8 .. 8+W-1: floor square root, one root bit per stage
	// ------------------------------------------------------------------------
	logic [W-1:0]      root_s8 [W][3];
	logic [W:0]        rem_s8  [W][3];
	logic [2*W-1:0]    rad_s8  [W][3];
	logic [5:0][W-1:0] cmp_s8  [W];

	for (genvar j = 0; j < W; j++) begin : g_sqrt
		logic [W-1:0]      r_src [3];
		logic [W:0]        m_src [3];
		logic [2*W-1:0]    v_src [3];
		logic [5:0][W-1:0] c_src;
		logic [W+2:0]      cand  [3];
		logic [W+2:0]      trial [3];
		logic [W+2:0]      diff  [3];
		logic [2:0]        ge;

		if (j == 0) begin : g_first
			always_comb begin
				for (int m = 0; m < 3; m++) begin
					r_src[m] = '0;
					m_src[m] = '0;
					v_src[m] = msq_s7[m];
				end
				c_src = comp_s7;
			end
		end else begin : g_next
			always_comb begin
				for (int m = 0; m < 3; m++) begin
					r_src[m] = root_s8[j-1][m];
					m_src[m] = rem_s8[j-1][m];
					v_src[m] = rad_s8[j-1][m];
				end
				c_src = cmp_s8[j-1];
			end
		end

		always_comb begin
			for (int m = 0; m < 3; m++) begin
				cand[m]  = {m_src[m], v_src[m][2*W-1:2*W-2]};
				trial[m] = (W+3)'({r_src[m], 2'b01});
				ge[m]    = cand[m] >= trial[m];
				diff[m]  = cand[m] - trial[m];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[S_SQ+j]) begin
				for (int m = 0; m < 3; m++) begin
					root_s8[j][m] <= {r_src[m][W-2:0], ge[m]};
					rem_s8[j][m]  <= ge[m] ? diff[m][W:0] : cand[m][W:0];
					rad_s8[j][m]  <= v_src[m] << 2;
				end
				cmp_s8[j] <= c_src;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stage 8+W: ratio dividends 10000*|x| + |pos|/2, saturation check
	// stages 8+W+1 .. 8+W+16: restoring divide, one quotient bit per stage
	// ratio 0 is negative over positive, ratio 1 is zero over positive
	// ------------------------------------------------------------------------
	logic [W-1:0]      pm_s9    [RB+1];
	logic [W-1:0]      drem_s9  [RB+1][2];
	logic [RB-1:0]     dlow_s9  [RB+1][2];
	logic [RB-1:0]     quo_s9   [RB+1][2];
	logic [1:0]        sat_s9   [RB+1];
	logic              nopos_s9 [RB+1];
	logic [5:0][W-1:0] cmp_s9   [RB+1];

	logic [W-1:0]  pm_c;
	logic [W-1:0]  nm_c [2];
	logic [DW-1:0] dd_c [2];

	always_comb begin
		pm_c    = root_s8[W-1][1];
		nm_c[0] = root_s8[W-1][2];
		nm_c[1] = root_s8[W-1][0];
		for (int r = 0; r < 2; r++) begin
			dd_c[r] = DW'(nm_c[r]) * DW'(scu_pkg::RATIO_SCALE) + DW'(pm_c >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[S_DV]) begin
			pm_s9[0]    <= pm_c;
			nopos_s9[0] <= pm_c == '0;
			for (int r = 0; r < 2; r++) begin
				sat_s9[0][r]  <= dd_c[r] >= (DW'(pm_c) << RB);
				drem_s9[0][r] <= dd_c[r][DW-1:RB];
				dlow_s9[0][r] <= dd_c[r][RB-1:0];
				quo_s9[0][r]  <= '0;
			end
			cmp_s9[0] <= cmp_s8[W-1];
		end
	end

	for (genvar k = 1; k <= RB; k++) begin : g_div
		logic [W:0] dcand [2];
		logic [W:0] ddiff [2];
		logic [1:0] dge;

		always_comb begin
			for (int r = 0; r < 2; r++) begin
				dcand[r] = {drem_s9[k-1][r], dlow_s9[k-1][r][RB-1]};
				dge[r]   = dcand[r] >= (W+1)'(pm_s9[k-1]);
				ddiff[r] = dcand[r] - (W+1)'(pm_s9[k-1]);
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[S_DV+k]) begin
				pm_s9[k]    <= pm_s9[k-1];
				nopos_s9[k] <= nopos_s9[k-1];
				sat_s9[k]   <= sat_s9[k-1];
				for (int r = 0; r < 2; r++) begin
					drem_s9[k][r] <= dge[r] ? ddiff[r][W-1:0] : dcand[r][W-1:0];
					dlow_s9[k][r] <= dlow_s9[k-1][r] << 1;
					quo_s9[k][r]  <= {quo_s9[k-1][r][RB-2:0], dge[r]};
				end
				cmp_s9[k] <= cmp_s9[k-1];
			end
		end
	end

	// ------------------------------------------------------------------------
	// output fields
	// ------------------------------------------------------------------------
	logic [RB-1:0] ratio_c [2];

	always_comb begin
		for (int r = 0; r < 2; r++) begin
			if (nopos_s9[RB]) begin
				ratio_c[r] = '0;
			end else if (sat_s9[RB][r]) begin
				ratio_c[r] = '1;
			end else begin
				ratio_c[r] = quo_s9[RB][r];
			end
		end
	end

	assign zero_seq_re    = $signed(cmp_s9[RB][0]);
	assign zero_seq_im    = $signed(cmp_s9[RB][1]);
	assign pos_seq_re     = $signed(cmp_s9[RB][2]);
	assign pos_seq_im     = $signed(cmp_s9[RB][3]);
	assign neg_seq_re     = $signed(cmp_s9[RB][4]);
	assign neg_seq_im     = $signed(cmp_s9[RB][5]);
	assign neg_unbalance  = ratio_c[0];
	assign zero_unbalance = ratio_c[1];
	assign no_positive    = nopos_s9[RB];

endmodule

`default_nettype wire
